FILE: design/radial_sweep_pixel_inverter_macros.svh
// Assertion macros shared by the sweep inverter RTL.
`ifndef RADIAL_SWEEP_PIXEL_INVERTER_MACROS_SVH
`define RADIAL_SWEEP_PIXEL_INVERTER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RSPI_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RSPI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/rspi_pkg.sv
package rspi_pkg;

    // Frame geometry.
    localparam int FRAME_WIDTH  = 144;
    localparam int FRAME_HEIGHT = 168;
    localparam int HALF_W       = FRAME_WIDTH / 2;
    localparam int HALF_H       = FRAME_HEIGHT / 2;

    // Datapath widths: 9-bit signed row offset, Q4.12 cotangent, product and edge column.
    localparam int DY_W     = 9;
    localparam int COT_W    = 17;
    localparam int COT_FRAC = 12;
    localparam int PROD_W   = DY_W + COT_W;
    localparam int EDGE_W   = PROD_W - COT_FRAC + 1;

    // Seconds per minute and the quadrant boundaries of the sweep.
    localparam logic [5:0] SEC_WRAP = 6'd60;
    localparam logic [5:0] SEC_Q1   = 6'd15;
    localparam logic [5:0] SEC_Q2   = 6'd30;
    localparam logic [5:0] SEC_Q3   = 6'd45;

    // Configuration register indexes.
    localparam logic [2:0] REG_DAY_PRIMARY     = 3'd0;
    localparam logic [2:0] REG_DAY_SECONDARY   = 3'd1;
    localparam logic [2:0] REG_NIGHT_PRIMARY   = 3'd2;
    localparam logic [2:0] REG_NIGHT_SECONDARY = 3'd3;
    localparam logic [2:0] REG_NIGHT_ENABLE    = 3'd4;
    localparam logic [2:0] REG_NIGHT_START     = 3'd5;
    localparam logic [2:0] REG_NIGHT_END       = 3'd6;

    // Configuration register contents.
    typedef struct packed {
        logic [7:0]  day_primary;
        logic [7:0]  day_secondary;
        logic [7:0]  night_primary;
        logic [7:0]  night_secondary;
        logic        night_enable;
        logic [10:0] night_start;
        logic [10:0] night_end;
    } t_cfg;

    // Active color pair after the day/night and odd-minute choice.
    typedef struct packed {
        logic [7:0] pri;
        logic [7:0] sec;
    } t_pair;

    // Cotangent of the sweep angle per second, signed Q4.12.
    function automatic logic signed [COT_W-1:0] cot_lookup(input logic [5:0] s);
        logic signed [COT_W-1:0] v;
        case (s)
            6'd1:  v = -17'sd431;
            6'd2:  v = -17'sd871;
            6'd3:  v = -17'sd1331;
            6'd4:  v = -17'sd1824;
            6'd5:  v = -17'sd2365;
            6'd6:  v = -17'sd2976;
            6'd7:  v = -17'sd3688;
            6'd8:  v = -17'sd4549;
            6'd9:  v = -17'sd5638;
            6'd10: v = -17'sd7094;
            6'd11: v = -17'sd9200;
            6'd12: v = -17'sd12606;
            6'd13: v = -17'sd19270;
            6'd14: v = -17'sd38971;
            6'd16: v = 17'sd38971;
            6'd17: v = 17'sd19270;
            6'd18: v = 17'sd12606;
            6'd19: v = 17'sd9200;
            6'd20: v = 17'sd7094;
            6'd21: v = 17'sd5638;
            6'd22: v = 17'sd4549;
            6'd23: v = 17'sd3688;
            6'd24: v = 17'sd2976;
            6'd25: v = 17'sd2365;
            6'd26: v = 17'sd1824;
            6'd27: v = 17'sd1331;
            6'd28: v = 17'sd871;
            6'd29: v = 17'sd431;
            6'd31: v = -17'sd431;
            6'd32: v = -17'sd871;
            6'd33: v = -17'sd1331;
            6'd34: v = -17'sd1824;
            6'd35: v = -17'sd2365;
            6'd36: v = -17'sd2976;
            6'd37: v = -17'sd3688;
            6'd38: v = -17'sd4549;
            6'd39: v = -17'sd5638;
            6'd40: v = -17'sd7094;
            6'd41: v = -17'sd9200;
            6'd42: v = -17'sd12606;
            6'd43: v = -17'sd19270;
            6'd44: v = -17'sd38971;
            6'd46: v = 17'sd38971;
            6'd47: v = 17'sd19270;
            6'd48: v = 17'sd12606;
            6'd49: v = 17'sd9200;
            6'd50: v = 17'sd7094;
            6'd51: v = 17'sd5638;
            6'd52: v = 17'sd4549;
            6'd53: v = 17'sd3688;
            6'd54: v = 17'sd2976;
            6'd55: v = 17'sd2365;
            6'd56: v = 17'sd1824;
            6'd57: v = 17'sd1331;
            6'd58: v = 17'sd871;
            6'd59: v = 17'sd431;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

FILE: design/radial_sweep_pixel_inverter.sv
// Throughput: one request per cycle unless i_stall holds the pipeline; the three
// register stages are the lookup, the 9x17 multiply, and the edge compare with the
// color swap, which loads the output register.
// Reset (synchronous, active low) empties the pipeline and loads the default
// day and night colors and night window.
module radial_sweep_pixel_inverter
    import rspi_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [10:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_pixel_x,
    input  logic [7:0]  i_pixel_y,
    input  logic [5:0]  i_second,
    input  logic [4:0]  i_hour,
    input  logic [5:0]  i_minute,
    input  logic [7:0]  i_colour_in,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_colour_out,
    output logic        o_inverted
);

`include "radial_sweep_pixel_inverter_macros.svh"

    // Configuration registers.
    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.day_primary     <= 8'd195;
            r_cfg.day_secondary   <= 8'd255;
            r_cfg.night_primary   <= 8'd213;
            r_cfg.night_secondary <= 8'd192;
            r_cfg.night_enable    <= 1'b0;
            r_cfg.night_start     <= 11'd1408;
            r_cfg.night_end       <= 11'd384;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_DAY_PRIMARY:     r_cfg.day_primary     <= i_cfg_data[7:0];
                REG_DAY_SECONDARY:   r_cfg.day_secondary   <= i_cfg_data[7:0];
                REG_NIGHT_PRIMARY:   r_cfg.night_primary   <= i_cfg_data[7:0];
                REG_NIGHT_SECONDARY: r_cfg.night_secondary <= i_cfg_data[7:0];
                REG_NIGHT_ENABLE:    r_cfg.night_enable    <= i_cfg_data[0];
                REG_NIGHT_START:     r_cfg.night_start     <= i_cfg_data;
                REG_NIGHT_END:       r_cfg.night_end       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Stage enables: a stage loads when it is empty or its contents move on.
    logic r_v1, r_v2, r_v3;
    logic en1, en2, en3;

    assign en3     = !r_v3 || !i_stall;
    assign en2     = !r_v2 || en3;
    assign en1     = !r_v1 || en2;
    assign o_stall = !en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
        end
    end

    // Stage 1: wrap the second, offset the row, look up the cotangent, pick colors.
    t_pair                   pair;
    logic [5:0]              n_s1;
    logic signed [DY_W-1:0]  n_dy1;
    logic                    n_top1;
    logic                    n_left1;

    rspi_scheme u_scheme (
        .i_cfg    (r_cfg),
        .i_hour   (i_hour),
        .i_minute (i_minute),
        .o_pair   (pair)
    );

    assign n_s1    = (i_second >= SEC_WRAP) ? i_second - SEC_WRAP : i_second;
    assign n_dy1   = $signed({1'b0, i_pixel_y}) - $signed(DY_W'(HALF_H));
    assign n_top1  = {1'b0, i_pixel_y} <= DY_W'(HALF_H);
    assign n_left1 = {1'b0, i_pixel_x} <= DY_W'(HALF_W);

    logic [7:0]              r_x1;
    logic signed [DY_W-1:0]  r_dy1;
    logic signed [COT_W-1:0] r_cot1;
    logic [5:0]              r_s1;
    logic                    r_top1;
    logic                    r_left1;
    logic [7:0]              r_cin1;
    t_pair                   r_pair1;

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_x1    <= i_pixel_x;
            r_dy1   <= n_dy1;
            r_cot1  <= cot_lookup(n_s1);
            r_s1    <= n_s1;
            r_top1  <= n_top1;
            r_left1 <= n_left1;
            r_cin1  <= i_colour_in;
            r_pair1 <= pair;
        end
    end

    // Stage 2: row offset times cotangent.
    logic signed [PROD_W-1:0] n_p2;
    assign n_p2 = PROD_W'(r_dy1) * PROD_W'(r_cot1);

    logic signed [PROD_W-1:0] r_p2;
    logic [7:0]               r_x2;
    logic [5:0]               r_s2;
    logic                     r_top2;
    logic                     r_left2;
    logic [7:0]               r_cin2;
    t_pair                    r_pair2;

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_p2    <= n_p2;
            r_x2    <= r_x1;
            r_s2    <= r_s1;
            r_top2  <= r_top1;
            r_left2 <= r_left1;
            r_cin2  <= r_cin1;
            r_pair2 <= r_pair1;
        end
    end

    // Stage 3: scale toward zero, place the edge, test the quadrant, swap the color.
    logic signed [PROD_W-1:0] p_adj;
    logic signed [EDGE_W-1:0] xi;
    logic signed [EDGE_W-1:0] x_s;
    logic                     x_lt_edge;
    logic                     x_in_frame;
    logic                     x_pos;
    logic                     n_inv3;
    logic [7:0]               n_colour3;

    // Negative products get a bias so the shift truncates toward zero.
    assign p_adj = r_p2 + (r_p2[PROD_W-1] ? PROD_W'((1 << COT_FRAC) - 1) : '0);
    assign xi    = $signed({p_adj[PROD_W-1], p_adj[PROD_W-1:COT_FRAC]})
                 + $signed(EDGE_W'(HALF_W));
    assign x_s   = $signed({{(EDGE_W-8){1'b0}}, r_x2});

    assign x_lt_edge  = x_s < xi;
    assign x_in_frame = {1'b0, r_x2} < 9'(FRAME_WIDTH);
    assign x_pos      = r_x2 != 8'd0;

    always_comb begin
        n_inv3 = 1'b0;
        if (r_s2 != 6'd0) begin
            if (r_top2 && !r_left2) begin
                n_inv3 = (r_s2 >= SEC_Q1) || (x_pos && x_lt_edge);
            end else if (!r_top2 && !r_left2) begin
                n_inv3 = (r_s2 >= SEC_Q2) || (r_s2 > SEC_Q1 && x_in_frame && !x_lt_edge);
            end else if (!r_top2 && r_left2) begin
                n_inv3 = (r_s2 >= SEC_Q3) || (r_s2 > SEC_Q2 && x_in_frame && !x_lt_edge);
            end else begin
                n_inv3 = (r_s2 > SEC_Q3) && x_pos && x_lt_edge;
            end
        end
    end

    assign n_colour3 = !n_inv3 ? r_cin2
                     : (r_cin2 == r_pair2.pri) ? r_pair2.sec : r_pair2.pri;

    logic [7:0] r_colour3;
    logic       r_inv3;

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_colour3 <= n_colour3;
            r_inv3    <= n_inv3;
        end
    end

    assign o_valid      = r_v3;
    assign o_colour_out = r_colour3;
    assign o_inverted   = r_inv3;

    // Checks on the pipeline control and the zero-second rule.
    `RSPI_ASSERT_SAME(a_stall_only_full, o_stall, r_v1 && r_v2 && r_v3,
        "input stalled while the pipeline has a free stage")
    `RSPI_ASSERT_NEXT(a_request_enters, i_valid && !o_stall, r_v1,
        "accepted request did not enter stage 1")
    `RSPI_ASSERT_NEXT(a_stage2_moves, r_v2 && en3, r_v3,
        "stage 2 result lost on its way to the output")
    `RSPI_ASSERT_NEXT(a_second_zero, r_v2 && en3 && r_s2 == 6'd0, !o_inverted,
        "pixel inverted at second zero")

endmodule

FILE: design/rspi_scheme.sv
module rspi_scheme
    import rspi_pkg::*;
(
    input  t_cfg       i_cfg,
    input  logic [4:0] i_hour,
    input  logic [5:0] i_minute,
    output t_pair      o_pair
);

    logic [4:0] start_h;
    logic [5:0] start_m;
    logic [4:0] end_h;
    logic [5:0] end_m;
    logic       is_day;
    logic       odd;
    logic [7:0] base_pri;
    logic [7:0] base_sec;

    // Split the night window into hour and minute.
    assign start_h = i_cfg.night_start[10:6];
    assign start_m = i_cfg.night_start[5:0];
    assign end_h   = i_cfg.night_end[10:6];
    assign end_m   = i_cfg.night_end[5:0];

    // Day holds from the night end up to the night start, or always when night is off.
    assign is_day = !i_cfg.night_enable
                 || (i_hour == end_h && i_minute >= end_m)
                 || (i_hour > end_h && i_hour < start_h)
                 || (i_hour == start_h && i_minute < start_m);

    assign base_pri = is_day ? i_cfg.day_primary   : i_cfg.night_primary;
    assign base_sec = is_day ? i_cfg.day_secondary : i_cfg.night_secondary;

    // Odd minutes swap the two colors.
    assign odd        = i_minute[0];
    assign o_pair.pri = odd ? base_sec : base_pri;
    assign o_pair.sec = odd ? base_pri : base_sec;

endmodule
